@@ src/quaternion_rotation_alu_assert.svh @@
// ----------------------------------------------------------------------------
// quaternion rotation alu assertion macros
// shared property forms for the port checker
// ----------------------------------------------------------------------------
`ifndef QUATERNION_ROTATION_ALU_ASSERT_SVH
`define QUATERNION_ROTATION_ALU_ASSERT_SVH

// same-cycle implication, off during reset
`define QRA_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("qra assertion failed");

// next-cycle implication, off during reset
`define QRA_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("qra assertion failed");

// next-cycle implication, checked during reset too
`define QRA_ASSERT_ALW(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("qra assertion failed");

`endif

@@ src/qra_pkg.sv @@
// ----------------------------------------------------------------------------
// qra_pkg
// op codes, rounding modes and stage control types of the quaternion alu
// ----------------------------------------------------------------------------
`default_nettype none

package qra_pkg;

    localparam int OP_W = 3;

    localparam logic [OP_W-1:0] OP_PRODUCT = 3'd0;
    localparam logic [OP_W-1:0] OP_CONJ    = 3'd1;
    localparam logic [OP_W-1:0] OP_ROTATE  = 3'd2;
    localparam logic [OP_W-1:0] OP_DOT     = 3'd3;
    localparam logic [OP_W-1:0] OP_INVERT  = 3'd4;

    // component slots
    localparam int IX = 0;
    localparam int IY = 1;
    localparam int IZ = 2;
    localparam int IW = 3;

    typedef enum logic [1:0] {
        MODE_FRAC = 2'd0,
        MODE_ROT  = 2'd1,
        MODE_RAW  = 2'd2
    } t_mode;

    typedef struct packed {
        logic            valid;
        logic [OP_W-1:0] op;
    } t_op_ctl;

    typedef struct packed {
        logic  valid;
        t_mode mode;
    } t_acc_ctl;

endpackage

`default_nettype wire

@@ src/qra_mul_stage.sv @@
// ----------------------------------------------------------------------------
// qra_mul_stage
// first stage: all component products q*p and the squares of q
// ----------------------------------------------------------------------------
`default_nettype none

module qra_mul_stage #(
    parameter int COMP_WIDTH = 16
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire qra_pkg::t_op_ctl        i_ctl,
    output logic                         o_ready,
    input  wire logic signed [COMP_WIDTH-1:0]   i_q [4],
    input  wire logic signed [COMP_WIDTH-1:0]   i_p [4],
    output qra_pkg::t_op_ctl             o_ctl,
    input  wire                          i_ready,
    output logic signed [2*COMP_WIDTH-1:0] o_prod [4][4],
    output logic signed [2*COMP_WIDTH-1:0] o_sq [4],
    output logic signed [COMP_WIDTH-1:0]   o_q [4],
    output logic signed [COMP_WIDTH-1:0]   o_p [4]
);

    localparam int PW = 2*COMP_WIDTH;

    logic                          r_valid;
    logic [qra_pkg::OP_W-1:0]      r_op;
    logic signed [PW-1:0]          r_prod [4][4];
    logic signed [PW-1:0]          r_sq [4];
    logic signed [COMP_WIDTH-1:0]  r_q [4];
    logic signed [COMP_WIDTH-1:0]  r_p [4];

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_ctl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_ctl.valid) begin
            r_op <= i_ctl.op;
            for (int i = 0; i < 4; i++) begin
                for (int j = 0; j < 4; j++) begin
                    r_prod[i][j] <= i_q[i] * i_p[j];
                end
                r_sq[i] <= i_q[i] * i_q[i];
                r_q[i]  <= i_q[i];
                r_p[i]  <= i_p[i];
            end
        end
    end

    assign o_ctl.valid = r_valid;
    assign o_ctl.op    = r_op;
    assign o_prod      = r_prod;
    assign o_sq        = r_sq;
    assign o_q         = r_q;
    assign o_p         = r_p;

endmodule

`default_nettype wire

@@ src/qra_sum_stage.sv @@
// ----------------------------------------------------------------------------
// qra_sum_stage
// second stage: signed sums of products for product, conjugate, dot and rotation terms
// ----------------------------------------------------------------------------
`default_nettype none

module qra_sum_stage #(
    parameter int COMP_WIDTH = 16
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire qra_pkg::t_op_ctl        i_ctl,
    output logic                         o_ready,
    input  wire logic signed [2*COMP_WIDTH-1:0] i_prod [4][4],
    input  wire logic signed [2*COMP_WIDTH-1:0] i_sq [4],
    input  wire logic signed [COMP_WIDTH-1:0]   i_q [4],
    input  wire logic signed [COMP_WIDTH-1:0]   i_p [4],
    output qra_pkg::t_op_ctl             o_ctl,
    input  wire                          i_ready,
    output logic signed [2*COMP_WIDTH+1:0] o_sum [4],
    output logic signed [2*COMP_WIDTH+1:0] o_uv,
    output logic signed [2*COMP_WIDTH+1:0] o_sc,
    output logic signed [2*COMP_WIDTH+1:0] o_cr [3],
    output logic signed [COMP_WIDTH-1:0]   o_q [4],
    output logic signed [COMP_WIDTH-1:0]   o_p [4]
);

    localparam int SW = 2*COMP_WIDTH + 2;

    logic                          r_valid;
    logic [qra_pkg::OP_W-1:0]      r_op;
    logic signed [SW-1:0]          r_sum [4];
    logic signed [SW-1:0]          r_uv;
    logic signed [SW-1:0]          r_sc;
    logic signed [SW-1:0]          r_cr [3];
    logic signed [COMP_WIDTH-1:0]  r_q [4];
    logic signed [COMP_WIDTH-1:0]  r_p [4];

    logic signed [SW-1:0] e [4][4];
    logic signed [SW-1:0] vx, vy, vz, vw;
    logic signed [SW-1:0] n_sum [4];
    logic signed [SW-1:0] n_uv, n_sc;
    logic signed [SW-1:0] n_cr [3];

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            for (int j = 0; j < 4; j++) begin
                e[i][j] = SW'(i_prod[i][j]);
            end
        end
    end

    // parts that change sign under the conjugate
    assign vx = e[qra_pkg::IX][qra_pkg::IW] + e[qra_pkg::IY][qra_pkg::IZ]
              - e[qra_pkg::IZ][qra_pkg::IY];
    assign vy = e[qra_pkg::IY][qra_pkg::IW] + e[qra_pkg::IZ][qra_pkg::IX]
              - e[qra_pkg::IX][qra_pkg::IZ];
    assign vz = e[qra_pkg::IZ][qra_pkg::IW] + e[qra_pkg::IX][qra_pkg::IY]
              - e[qra_pkg::IY][qra_pkg::IX];
    assign vw = e[qra_pkg::IX][qra_pkg::IX] + e[qra_pkg::IY][qra_pkg::IY]
              + e[qra_pkg::IZ][qra_pkg::IZ];

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            n_sum[k] = '0;
        end
        case (i_ctl.op)
            qra_pkg::OP_PRODUCT: begin
                n_sum[qra_pkg::IX] = e[qra_pkg::IW][qra_pkg::IX] + vx;
                n_sum[qra_pkg::IY] = e[qra_pkg::IW][qra_pkg::IY] + vy;
                n_sum[qra_pkg::IZ] = e[qra_pkg::IW][qra_pkg::IZ] + vz;
                n_sum[qra_pkg::IW] = e[qra_pkg::IW][qra_pkg::IW] - vw;
            end
            qra_pkg::OP_CONJ: begin
                n_sum[qra_pkg::IX] = e[qra_pkg::IW][qra_pkg::IX] - vx;
                n_sum[qra_pkg::IY] = e[qra_pkg::IW][qra_pkg::IY] - vy;
                n_sum[qra_pkg::IZ] = e[qra_pkg::IW][qra_pkg::IZ] - vz;
                n_sum[qra_pkg::IW] = e[qra_pkg::IW][qra_pkg::IW] + vw;
            end
            qra_pkg::OP_DOT: begin
                n_sum[qra_pkg::IW] = e[qra_pkg::IW][qra_pkg::IW] + vw;
            end
            default: begin
                n_sum[qra_pkg::IW] = '0;
            end
        endcase
    end

    assign n_uv = vw;
    assign n_sc = SW'(i_sq[qra_pkg::IW]) - SW'(i_sq[qra_pkg::IX])
                - SW'(i_sq[qra_pkg::IY]) - SW'(i_sq[qra_pkg::IZ]);
    assign n_cr[0] = e[qra_pkg::IY][qra_pkg::IZ] - e[qra_pkg::IZ][qra_pkg::IY];
    assign n_cr[1] = e[qra_pkg::IZ][qra_pkg::IX] - e[qra_pkg::IX][qra_pkg::IZ];
    assign n_cr[2] = e[qra_pkg::IX][qra_pkg::IY] - e[qra_pkg::IY][qra_pkg::IX];

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_ctl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_ctl.valid) begin
            r_op <= i_ctl.op;
            r_uv <= n_uv;
            r_sc <= n_sc;
            for (int k = 0; k < 4; k++) begin
                r_sum[k] <= n_sum[k];
                r_q[k]   <= i_q[k];
                r_p[k]   <= i_p[k];
            end
            for (int k = 0; k < 3; k++) begin
                r_cr[k] <= n_cr[k];
            end
        end
    end

    assign o_ctl.valid = r_valid;
    assign o_ctl.op    = r_op;
    assign o_sum       = r_sum;
    assign o_uv        = r_uv;
    assign o_sc        = r_sc;
    assign o_cr        = r_cr;
    assign o_q         = r_q;
    assign o_p         = r_p;

endmodule

`default_nettype wire

@@ src/qra_rot_stage.sv @@
// ----------------------------------------------------------------------------
// qra_rot_stage
// third and fourth stages: rotation products, then one wide accumulator
// per component with its rounding mode
// ----------------------------------------------------------------------------
`default_nettype none

module qra_rot_stage #(
    parameter int COMP_WIDTH = 16
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire qra_pkg::t_op_ctl        i_ctl,
    output logic                         o_ready,
    input  wire logic signed [2*COMP_WIDTH+1:0] i_sum [4],
    input  wire logic signed [2*COMP_WIDTH+1:0] i_uv,
    input  wire logic signed [2*COMP_WIDTH+1:0] i_sc,
    input  wire logic signed [2*COMP_WIDTH+1:0] i_cr [3],
    input  wire logic signed [COMP_WIDTH-1:0]   i_q [4],
    input  wire logic signed [COMP_WIDTH-1:0]   i_p [4],
    output qra_pkg::t_acc_ctl            o_ctl,
    input  wire                          i_ready,
    output logic signed [3*COMP_WIDTH+4:0] o_acc [4]
);

    localparam int TW = 3*COMP_WIDTH + 2;
    localparam int AW = 3*COMP_WIDTH + 5;

    // multiply stage
    logic                  r_va;
    qra_pkg::t_mode        r_mode_a;
    logic signed [TW-1:0]  r_t0 [3];
    logic signed [TW-1:0]  r_t1 [3];
    logic signed [TW-1:0]  r_t2 [3];
    logic signed [AW-1:0]  r_acc_a [4];
    // accumulate stage
    logic                  r_vb;
    qra_pkg::t_mode        r_mode_b;
    logic signed [AW-1:0]  r_acc_b [4];

    logic                  w_rdy_b;
    qra_pkg::t_mode        n_mode;
    logic signed [AW-1:0]  n_acc_a [4];
    logic signed [AW-1:0]  n_acc_b [4];

    always_comb begin
        n_mode = qra_pkg::MODE_RAW;
        for (int k = 0; k < 4; k++) begin
            n_acc_a[k] = '0;
        end
        case (i_ctl.op)
            qra_pkg::OP_PRODUCT, qra_pkg::OP_CONJ, qra_pkg::OP_DOT: begin
                n_mode = qra_pkg::MODE_FRAC;
                for (int k = 0; k < 4; k++) begin
                    n_acc_a[k] = AW'(i_sum[k]);
                end
            end
            qra_pkg::OP_ROTATE: begin
                n_mode = qra_pkg::MODE_ROT;
            end
            qra_pkg::OP_INVERT: begin
                n_mode = qra_pkg::MODE_RAW;
                n_acc_a[qra_pkg::IX] = -AW'(i_q[qra_pkg::IX]);
                n_acc_a[qra_pkg::IY] = -AW'(i_q[qra_pkg::IY]);
                n_acc_a[qra_pkg::IZ] = -AW'(i_q[qra_pkg::IZ]);
                n_acc_a[qra_pkg::IW] = AW'(i_q[qra_pkg::IW]);
            end
            default: begin
                n_mode = qra_pkg::MODE_RAW;
            end
        endcase
    end

    assign o_ready = !r_va || w_rdy_b;
    assign w_rdy_b = !r_vb || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
        end else begin
            if (o_ready) begin
                r_va <= i_ctl.valid;
            end
            if (w_rdy_b) begin
                r_vb <= r_va;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_ctl.valid) begin
            r_mode_a <= n_mode;
            for (int k = 0; k < 3; k++) begin
                r_t0[k] <= i_q[k] * i_uv;
                r_t1[k] <= i_p[k] * i_sc;
                r_t2[k] <= i_q[qra_pkg::IW] * i_cr[k];
            end
            for (int k = 0; k < 4; k++) begin
                r_acc_a[k] <= n_acc_a[k];
            end
        end
    end

    // 2u(u.v) + v(w^2 - u.u) + 2w(u x v)
    always_comb begin
        for (int k = 0; k < 4; k++) begin
            n_acc_b[k] = r_acc_a[k];
        end
        if (r_mode_a == qra_pkg::MODE_ROT) begin
            for (int k = 0; k < 3; k++) begin
                n_acc_b[k] = (AW'(r_t0[k]) <<< 1) + AW'(r_t1[k]) + (AW'(r_t2[k]) <<< 1);
            end
            n_acc_b[qra_pkg::IW] = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy_b && r_va) begin
            r_mode_b <= r_mode_a;
            for (int k = 0; k < 4; k++) begin
                r_acc_b[k] <= n_acc_b[k];
            end
        end
    end

    assign o_ctl.valid = r_vb;
    assign o_ctl.mode  = r_mode_b;
    assign o_acc       = r_acc_b;

endmodule

`default_nettype wire

@@ src/qra_round_stage.sv @@
// ----------------------------------------------------------------------------
// qra_round_stage
// fifth and sixth stages: round half up by the mode's shift, then clip to
// the component range and register the result beat
// ----------------------------------------------------------------------------
`default_nettype none

module qra_round_stage #(
    parameter int COMP_WIDTH = 16,
    parameter int FRAC_BITS  = 14
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire qra_pkg::t_acc_ctl       i_ctl,
    output logic                         o_ready,
    input  wire logic signed [3*COMP_WIDTH+4:0] i_acc [4],
    output logic                         o_valid,
    input  wire                          i_ready,
    output logic signed [COMP_WIDTH-1:0] o_r [4],
    output logic                         o_sat
);

    localparam int AW = 3*COMP_WIDTH + 5;
    localparam logic signed [AW-1:0] ONE    = {{(AW-1){1'b0}}, 1'b1};
    localparam logic signed [AW-1:0] HALF_F = ONE <<< (FRAC_BITS - 1);
    localparam logic signed [AW-1:0] HALF_R = ONE <<< (3*FRAC_BITS - 1);
    localparam logic signed [AW-1:0] HI     = (ONE <<< (COMP_WIDTH - 1)) - ONE;
    localparam logic signed [AW-1:0] LO     = -(ONE <<< (COMP_WIDTH - 1));

    logic                          r_vc;
    logic signed [AW-1:0]          r_rnd [4];
    logic                          r_vd;
    logic signed [COMP_WIDTH-1:0]  r_out [4];
    logic                          r_sat;

    logic                          w_rdy_d;
    logic signed [AW-1:0]          n_rnd [4];
    logic signed [COMP_WIDTH-1:0]  n_out [4];
    logic                          n_sat;

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            case (i_ctl.mode)
                qra_pkg::MODE_FRAC: n_rnd[k] = (i_acc[k] + HALF_F) >>> FRAC_BITS;
                qra_pkg::MODE_ROT:  n_rnd[k] = (i_acc[k] + HALF_R) >>> (3*FRAC_BITS);
                default:            n_rnd[k] = i_acc[k];
            endcase
        end
    end

    always_comb begin
        n_sat = 1'b0;
        for (int k = 0; k < 4; k++) begin
            if (r_rnd[k] > HI) begin
                n_out[k] = HI[COMP_WIDTH-1:0];
                n_sat    = 1'b1;
            end else if (r_rnd[k] < LO) begin
                n_out[k] = LO[COMP_WIDTH-1:0];
                n_sat    = 1'b1;
            end else begin
                n_out[k] = r_rnd[k][COMP_WIDTH-1:0];
            end
        end
    end

    assign o_ready = !r_vc || w_rdy_d;
    assign w_rdy_d = !r_vd || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vc <= 1'b0;
            r_vd <= 1'b0;
        end else begin
            if (o_ready) begin
                r_vc <= i_ctl.valid;
            end
            if (w_rdy_d) begin
                r_vd <= r_vc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_ctl.valid) begin
            for (int k = 0; k < 4; k++) begin
                r_rnd[k] <= n_rnd[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy_d && r_vc) begin
            r_sat <= n_sat;
            for (int k = 0; k < 4; k++) begin
                r_out[k] <= n_out[k];
            end
        end
    end

    assign o_valid = r_vd;
    assign o_r     = r_out;
    assign o_sat   = r_sat;

endmodule

`default_nettype wire

@@ src/quaternion_rotation_alu.sv @@
// throughput: one beat per cycle unless the output stalls, set by the six register stages
// (products, sums, rotation products, accumulate, round, clip)
// a stalled output lets earlier stages fill their empty slots
// reset: synchronous active low, clears only the stage valid bits
// ----------------------------------------------------------------------------
// quaternion_rotation_alu
// hamilton product, conjugate product, vector rotation, dot and conjugate
// of q on signed fixed-point quaternions, rounded and saturated
// ----------------------------------------------------------------------------
`default_nettype none

module quaternion_rotation_alu #(
    parameter int COMP_WIDTH = 16,
    parameter int FRAC_BITS  = 14
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_valid,
    output logic                         o_ready,
    input  wire [qra_pkg::OP_W-1:0]      i_op,
    input  wire logic signed [COMP_WIDTH-1:0] i_q_x,
    input  wire logic signed [COMP_WIDTH-1:0] i_q_y,
    input  wire logic signed [COMP_WIDTH-1:0] i_q_z,
    input  wire logic signed [COMP_WIDTH-1:0] i_q_w,
    input  wire logic signed [COMP_WIDTH-1:0] i_p_x,
    input  wire logic signed [COMP_WIDTH-1:0] i_p_y,
    input  wire logic signed [COMP_WIDTH-1:0] i_p_z,
    input  wire logic signed [COMP_WIDTH-1:0] i_p_w,
    output logic                         o_valid,
    input  wire                          i_ready,
    output logic signed [COMP_WIDTH-1:0] o_r_x,
    output logic signed [COMP_WIDTH-1:0] o_r_y,
    output logic signed [COMP_WIDTH-1:0] o_r_z,
    output logic signed [COMP_WIDTH-1:0] o_r_w,
    output logic                         o_saturated
);

    localparam int PW = 2*COMP_WIDTH;
    localparam int SW = 2*COMP_WIDTH + 2;
    localparam int AW = 3*COMP_WIDTH + 5;

    qra_pkg::t_op_ctl             w_in_ctl;
    logic signed [COMP_WIDTH-1:0] w_q [4];
    logic signed [COMP_WIDTH-1:0] w_p [4];

    qra_pkg::t_op_ctl             w_ctl1;
    logic                         w_rdy1;
    logic signed [PW-1:0]         w_prod [4][4];
    logic signed [PW-1:0]         w_sq [4];
    logic signed [COMP_WIDTH-1:0] w_q1 [4];
    logic signed [COMP_WIDTH-1:0] w_p1 [4];

    qra_pkg::t_op_ctl             w_ctl2;
    logic                         w_rdy2;
    logic signed [SW-1:0]         w_sum [4];
    logic signed [SW-1:0]         w_uv;
    logic signed [SW-1:0]         w_sc;
    logic signed [SW-1:0]         w_cr [3];
    logic signed [COMP_WIDTH-1:0] w_q2 [4];
    logic signed [COMP_WIDTH-1:0] w_p2 [4];

    qra_pkg::t_acc_ctl            w_ctl3;
    logic                         w_rdy3;
    logic signed [AW-1:0]         w_acc [4];

    logic signed [COMP_WIDTH-1:0] w_r [4];

    assign w_in_ctl.valid = i_valid;
    assign w_in_ctl.op    = i_op;

    assign w_q[qra_pkg::IX] = i_q_x;
    assign w_q[qra_pkg::IY] = i_q_y;
    assign w_q[qra_pkg::IZ] = i_q_z;
    assign w_q[qra_pkg::IW] = i_q_w;
    assign w_p[qra_pkg::IX] = i_p_x;
    assign w_p[qra_pkg::IY] = i_p_y;
    assign w_p[qra_pkg::IZ] = i_p_z;
    assign w_p[qra_pkg::IW] = i_p_w;

    qra_mul_stage #(
        .COMP_WIDTH (COMP_WIDTH)
    ) u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_in_ctl),
        .o_ready (o_ready),
        .i_q     (w_q),
        .i_p     (w_p),
        .o_ctl   (w_ctl1),
        .i_ready (w_rdy1),
        .o_prod  (w_prod),
        .o_sq    (w_sq),
        .o_q     (w_q1),
        .o_p     (w_p1)
    );

    qra_sum_stage #(
        .COMP_WIDTH (COMP_WIDTH)
    ) u_sum (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl1),
        .o_ready (w_rdy1),
        .i_prod  (w_prod),
        .i_sq    (w_sq),
        .i_q     (w_q1),
        .i_p     (w_p1),
        .o_ctl   (w_ctl2),
        .i_ready (w_rdy2),
        .o_sum   (w_sum),
        .o_uv    (w_uv),
        .o_sc    (w_sc),
        .o_cr    (w_cr),
        .o_q     (w_q2),
        .o_p     (w_p2)
    );

    qra_rot_stage #(
        .COMP_WIDTH (COMP_WIDTH)
    ) u_rot (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl2),
        .o_ready (w_rdy2),
        .i_sum   (w_sum),
        .i_uv    (w_uv),
        .i_sc    (w_sc),
        .i_cr    (w_cr),
        .i_q     (w_q2),
        .i_p     (w_p2),
        .o_ctl   (w_ctl3),
        .i_ready (w_rdy3),
        .o_acc   (w_acc)
    );

    qra_round_stage #(
        .COMP_WIDTH (COMP_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_round (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl3),
        .o_ready (w_rdy3),
        .i_acc   (w_acc),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_r     (w_r),
        .o_sat   (o_saturated)
    );

    assign o_r_x = w_r[qra_pkg::IX];
    assign o_r_y = w_r[qra_pkg::IY];
    assign o_r_z = w_r[qra_pkg::IZ];
    assign o_r_w = w_r[qra_pkg::IW];

endmodule

`default_nettype wire

@@ src/qra_assert_chk.sv @@
// ----------------------------------------------------------------------------
// qra_assert_chk
// port-level checks on the quaternion alu, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "quaternion_rotation_alu_assert.svh"

module qra_assert_chk #(
    parameter int COMP_WIDTH = 16
) (
    input wire                          i_clk,
    input wire                          i_rst_n,
    input wire                          o_ready,
    input wire                          o_valid,
    input wire                          i_ready,
    input wire signed [COMP_WIDTH-1:0]  o_r_x,
    input wire signed [COMP_WIDTH-1:0]  o_r_y,
    input wire signed [COMP_WIDTH-1:0]  o_r_z,
    input wire signed [COMP_WIDTH-1:0]  o_r_w,
    input wire                          o_saturated
);

    localparam logic signed [COMP_WIDTH-1:0] HI = {1'b0, {(COMP_WIDTH-1){1'b1}}};
    localparam logic signed [COMP_WIDTH-1:0] LO = {1'b1, {(COMP_WIDTH-1){1'b0}}};

    wire [4*COMP_WIDTH:0] w_res = {o_r_x, o_r_y, o_r_z, o_r_w, o_saturated};
    wire                  w_rail = (o_r_x == HI) || (o_r_x == LO) || (o_r_y == HI)
                                || (o_r_y == LO) || (o_r_z == HI) || (o_r_z == LO)
                                || (o_r_w == HI) || (o_r_w == LO);

    // stalled result beat holds
    `QRA_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid && $stable(w_res))

    // no result beat right after a reset cycle
    `QRA_ASSERT_ALW(a_rst_empty, i_clk, !i_rst_n, !o_valid)

    // input stalls only while a result beat is stalled at the output
    `QRA_ASSERT_IMP(a_full_stall, i_clk, i_rst_n, !o_ready, o_valid && !i_ready)

    // a clipped beat shows at least one rail value
    `QRA_ASSERT_IMP(a_sat_rail, i_clk, i_rst_n, o_valid && o_saturated, w_rail)

endmodule

bind quaternion_rotation_alu qra_assert_chk #(
    .COMP_WIDTH (COMP_WIDTH)
) u_qra_assert_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_ready     (o_ready),
    .o_valid     (o_valid),
    .i_ready     (i_ready),
    .o_r_x       (o_r_x),
    .o_r_y       (o_r_y),
    .o_r_z       (o_r_z),
    .o_r_w       (o_r_w),
    .o_saturated (o_saturated)
);

`default_nettype wire
